/* rtl/psd_pkg.sv */
// psd_pkg: shared widths, register map and reset values of the six-leg drive scaler
// used by every rtl file of the block; no dependencies
package psd_pkg;
  localparam int unsigned LegSlots  = 6;
  localparam int unsigned LegCountDefault = 6;
  localparam int unsigned ErrW  = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned PulseW = 16;
  localparam int unsigned ProdW = ErrW + GainW + 1;
  localparam int unsigned MagW  = 31;
  localparam int unsigned NumW  = MagW + PulseW;
  localparam int unsigned QuoW  = 16;
  localparam int unsigned AddrW = 5;
  localparam int unsigned RegIdxW = 3;

  localparam logic [GainW-1:0]  GainReset   = 16'd256;
  localparam logic [PulseW-1:0] PeriodReset = 16'd1000;
  localparam logic [PulseW-1:0] FloorReset  = 16'd0;

  // register indexes, byte address is 4 * index
  localparam logic [RegIdxW-1:0] RegLeg1Gain = 3'd0;
  localparam logic [RegIdxW-1:0] RegLeg2Gain = 3'd1;
  localparam logic [RegIdxW-1:0] RegPeriod = 3'd6;
  localparam logic [RegIdxW-1:0] RegFloor  = 3'd7;

  // scaling kicks in once the largest magnitude exceeds 1.0 in Q16.16
  localparam logic [MagW-1:0] MagUnity = 31'd65536;
endpackage

/* rtl/psd_lane.sv */
// psd_lane: per-leg front end, gain multiply, magnitude and period multiply
// depends on psd_pkg
module psd_lane import psd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  logic signed [ErrW-1:0]   error_i,
  input  logic [GainW-1:0]         gain_i,
  input  logic [PulseW-1:0]        period_i,
  output logic [MagW-1:0]          mag_o,
  output logic [NumW-1:0]          num_o,
  output logic                     fwd_o
);
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [NumW-1:0] num2_q, num2_d;
  logic fwd2_q, fwd3_q;
  logic [ProdW-1:0] abs_w;

  assign prod_d = ProdW'(error_i) * ProdW'($signed({1'b0, gain_i}));
  assign abs_w  = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
  assign mag_d  = abs_w[MagW-1:0];
  assign num2_d = NumW'(mag_q) * NumW'(period_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      mag_q  <= mag_d;
      fwd2_q <= ~prod_q[ProdW-1];
      num2_q <= num2_d;
      fwd3_q <= fwd2_q;
    end
  end

  assign mag_o = mag_q;
  assign num_o = num2_q;
  assign fwd_o = fwd3_q;
  logic unused_w;
  assign unused_w = ^abs_w[ProdW-1:MagW];
endmodule

/* rtl/psd_merge.sv */
// psd_merge: finds the largest leg magnitude and the scale decision
// depends on psd_pkg
module psd_merge import psd_pkg::*; #(
  parameter int unsigned LegCount = LegCountDefault
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic [MagW-1:0]      mag_i [LegCount],
  output logic [MagW-1:0]      mag_max_o,
  output logic                 scale_o
);
  logic [MagW-1:0] max_d, max_q;

  always_comb begin
    max_d = '0;
    for (int i = 0; i < LegCount; i++) begin
      if (mag_i[i] > max_d) max_d = mag_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) max_q <= max_d;
  end

  assign mag_max_o = max_q;
  assign scale_o   = max_q > MagUnity;
endmodule

/* rtl/psd_div.sv */
// psd_div: per-leg pipelined restoring divider, one quotient bit per stage,
// then pulse select and floor; depends on psd_pkg
module psd_div import psd_pkg::*; (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [NumW-1:0]    num_i,
  input  logic [MagW-1:0]    den_i,
  input  logic               scale_i,
  input  logic               fwd_i,
  input  logic [PulseW-1:0]  floor_i,
  output logic [PulseW-1:0]  pulse_o,
  output logic               fwd_o
);
  logic [NumW-1:0]   rem_q  [QuoW+1];
  logic [MagW-1:0]   den_q  [QuoW+1];
  logic [QuoW-1:0]   quo_q  [QuoW+1];
  logic [PulseW-1:0] flat_q [QuoW+1];
  logic              sc_q   [QuoW+1];
  logic              fw_q   [QuoW+1];
  logic [PulseW-1:0] p_w, pulse_q;
  logic              fwd_q;

  assign rem_q[0]  = num_i;
  assign den_q[0]  = den_i;
  assign quo_q[0]  = '0;
  assign flat_q[0] = num_i[PulseW+15:16];
  assign sc_q[0]   = scale_i;
  assign fw_q[0]   = fwd_i;

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int unsigned K = QuoW - 1 - s;
    logic [NumW:0] sub_w;
    logic          take_w;
    assign sub_w  = {1'b0, rem_q[s]} - ((NumW+1)'(den_q[s]) << K);
    assign take_w = ~sub_w[NumW];
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1]  <= take_w ? sub_w[NumW-1:0] : rem_q[s];
        quo_q[s+1]  <= quo_q[s] | (QuoW'(take_w) << K);
        den_q[s+1]  <= den_q[s];
        flat_q[s+1] <= flat_q[s];
        sc_q[s+1]   <= sc_q[s];
        fw_q[s+1]   <= fw_q[s];
      end
    end
  end

  assign p_w = sc_q[QuoW] ? quo_q[QuoW] : flat_q[QuoW];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pulse_q <= (p_w < floor_i) ? floor_i : p_w;
      fwd_q   <= fw_q[QuoW];
    end
  end

  assign pulse_o = pulse_q;
  assign fwd_o   = fwd_q;
  logic unused_w;
  assign unused_w = ^{rem_q[QuoW], den_q[QuoW]};
endmodule

/* rtl/six_leg_p_drive_scaler.sv */
// six_leg_p_drive_scaler: top level, register file, lanes, merge and dividers
// depends on psd_pkg, psd_lane, psd_merge, psd_div
//
// Input stream carries six signed Q8.8 leg errors per beat; output stream
// carries six pulse counts and six direction bits per beat, one per input.
// Each leg is multiplied by its gain register, scaled by pwm_period, and if
// any leg exceeds full scale all legs are divided by the largest magnitude.
// The path runs through the multiply and max merge stages, the per-leg
// divider (one quotient bit per stage), then the floor and output register.
// Throughput is one beat per cycle while the output is not stalled; the
// whole pipeline moves as one.
// When the receiver stalls with a beat in the output register, the
// pipeline freezes and s_axis_tready falls; nothing is dropped.
// Reset clears all valid bits and loads gains 1.0, period 1000, floor 0.
// Registers sit on an APB port at byte address 4*index and are to be
// written only while no beat is in flight.
module six_leg_p_drive_scaler import psd_pkg::*; #(
  parameter int unsigned LegCount = LegCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // leg1_error..leg6_error, 16 bits each from bit 0 up
  input  logic [95:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // leg1_pulse..leg6_pulse (16 bits each), leg1_forward..leg6_forward, 2 zero bits
  output logic [103:0]        m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int unsigned Depth = 3 + QuoW + 1;

  logic [GainW-1:0]  gain_q [LegSlots];
  logic [PulseW-1:0] period_q, floor_q;
  logic [RegIdxW-1:0] idx_w;
  logic wr_w;

  assign idx_w  = paddr[AddrW-1:2];
  assign wr_w   = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LegSlots; i++) gain_q[i] <= GainReset;
      period_q <= PeriodReset;
      floor_q  <= FloorReset;
    end else if (wr_w) begin
      if (idx_w == RegPeriod) period_q <= pwdata[PulseW-1:0];
      else if (idx_w == RegFloor) floor_q <= pwdata[PulseW-1:0];
      else gain_q[idx_w] <= pwdata[GainW-1:0];
    end
  end

  always_comb begin
    if (idx_w == RegPeriod) prdata = 32'(period_q);
    else if (idx_w == RegFloor) prdata = 32'(floor_q);
    else prdata = 32'(gain_q[idx_w]);
  end

  logic [Depth-1:0] vld_q, vld_d;
  logic adv_w;

  assign adv_w         = ~vld_q[Depth-1] | m_axis_tready;
  assign s_axis_tready = adv_w;
  assign m_axis_tvalid = vld_q[Depth-1];
  assign vld_d         = {vld_q[Depth-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_w) vld_q <= vld_d;
  end

  logic [MagW-1:0] mag_w [LegCount];
  logic [NumW-1:0] num_w [LegCount];
  logic            fwd_w [LegCount];
  logic [MagW-1:0] max_w;
  logic            scale_w;
  logic [PulseW-1:0] pulse_w [LegSlots];
  logic              dir_w   [LegSlots];

  for (genvar l = 0; l < LegCount; l++) begin : g_lane
    psd_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv_w),
      .error_i  ($signed(s_axis_tdata[l*ErrW +: ErrW])),
      .gain_i   (gain_q[l]),
      .period_i (period_q),
      .mag_o    (mag_w[l]),
      .num_o    (num_w[l]),
      .fwd_o    (fwd_w[l])
    );
    psd_div u_div (
      .clk_i   (clk_i),
      .adv_i   (adv_w),
      .num_i   (num_w[l]),
      .den_i   (max_w),
      .scale_i (scale_w),
      .fwd_i   (fwd_w[l]),
      .floor_i (floor_q),
      .pulse_o (pulse_w[l]),
      .fwd_o   (dir_w[l])
    );
  end

  for (genvar l = LegCount; l < LegSlots; l++) begin : g_idle
    assign pulse_w[l] = '0;
    assign dir_w[l]   = 1'b0;
  end

  psd_merge #(.LegCount(LegCount)) u_merge (
    .clk_i     (clk_i),
    .adv_i     (adv_w),
    .mag_i     (mag_w),
    .mag_max_o (max_w),
    .scale_o   (scale_w)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < LegSlots; i++) begin
      m_axis_tdata[i*PulseW +: PulseW] = pulse_w[i];
      m_axis_tdata[LegSlots*PulseW + i] = dir_w[i];
    end
  end
endmodule

/* rtl/psd_checker.sv */
// psd_checker: port-level checks of the drive scaler, bound to the top level
// depends on psd_pkg
module psd_checker import psd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [103:0]        m_axis_tdata,
  input logic                pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with free output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && (s_axis_tready || (m_axis_tvalid && !m_axis_tready)))
    else $error("config or stream handshake stuck");
endmodule

bind six_leg_p_drive_scaler psd_checker u_psd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

/* sim/psd_checker.sv */
// psd_scoreboard: watches both streams and the register port of the drive scaler,
// predicts every output beat and compares it field by field; depends on psd_pkg
module psd_scoreboard import psd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_o
);
  typedef struct packed {
    logic [5:0]       fwd;
    logic [5:0][15:0] pulse;
  } drive_t;

  logic [15:0] gain_q [6];
  logic [15:0] period_q;
  logic [15:0] floor_q;
  drive_t      drive_q [$];

  assign pending_o = drive_q.size();

  function automatic drive_t drive_predict(logic [95:0] errs);
    drive_t r;
    logic [63:0] dem [6];
    logic [63:0] amax;
    logic [63:0] p;
    longint prod;
    logic signed [15:0] e;
    amax = 0;
    for (int i = 0; i < 6; i++) begin
      e = errs[16*i +: 16];
      prod = longint'(e) * longint'({16'd0, gain_q[i]});
      r.fwd[i] = (prod >= 0);
      dem[i] = 64'(prod < 0 ? -prod : prod) * 64'(period_q);
      if (dem[i] > amax) amax = dem[i];
    end
    for (int i = 0; i < 6; i++) begin
      if (amax > (64'(period_q) << 16)) p = (dem[i] * 64'(period_q)) / amax;
      else p = dem[i] >> 16;
      if (p < 64'(floor_q)) p = 64'(floor_q);
      r.pulse[i] = p[15:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_t exp_d;
    drive_t got;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) gain_q[i] <= GainReset;
      period_q <= PeriodReset;
      floor_q <= FloorReset;
      fail_count <= 0;
      drive_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[101:96], m_axis_tdata[95:0]};
        if (drive_q.size() == 0) begin
          $error("output beat with nothing expected");
          errs++;
        end else begin
          exp_d = drive_q.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got.pulse[i] !== exp_d.pulse[i]) begin
              $error("leg%0d_pulse expected %0d got %0d", i + 1, exp_d.pulse[i],
                     got.pulse[i]);
              errs++;
            end
            if (got.fwd[i] !== exp_d.fwd[i]) begin
              $error("leg%0d_forward expected %0d got %0d", i + 1, exp_d.fwd[i],
                     got.fwd[i]);
              errs++;
            end
          end
          if (m_axis_tdata[103:102] !== 2'b00) begin
            $error("pad bits expected 0 got %0d", m_axis_tdata[103:102]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      // prediction uses register values before any write at this edge
      if (s_axis_tvalid && s_axis_tready) drive_q.push_back(drive_predict(s_axis_tdata));
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:2] == RegPeriod) period_q <= pwdata[15:0];
        else if (paddr[4:2] == RegFloor) floor_q <= pwdata[15:0];
        else gain_q[paddr[4:2]] <= pwdata[15:0];
      end
    end
  end
endmodule

/* sim/tb_top.sv */
// tb_top: stimulus and verdict for the six-leg drive scaler
// depends on psd_pkg, six_leg_p_drive_scaler and psd_scoreboard
module tb_top import psd_pkg::*;;
  localparam int Latency = 20;
  localparam int CycleLimit = 600000;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [103:0] m_axis_tdata;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending;
  int cycles;
  bit rx_hold;

  six_leg_p_drive_scaler dut (.*);
  psd_scoreboard u_checker (.pending_o(pending), .*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off while rx_hold is set
  initial begin
    int w;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (rx_hold) begin
        m_axis_tready <= 0;
        repeat (200) @(posedge clk_i);
        rx_hold = 0;
      end
      if (w > 0) begin
        m_axis_tready <= 0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
    end
  end

  task automatic reg_write(logic [RegIdxW-1:0] idx, logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // tvalid stays up between back-to-back beats, drain drops it
  task automatic send_errors(logic [95:0] d, bit no_gap);
    int w;
    w = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10));
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_err();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [95:0] d;
    logic [15:0] v;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rx_hold = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed beats at reset settings: zero, extremes, mixed signs, one leg over
    send_errors('0, 0);
    send_errors({6{16'h7fff}}, 0);
    send_errors({6{16'h8000}}, 0);
    send_errors({16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000, 16'h0100}, 0);
    send_errors({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0400}, 0);
    send_errors({16'h0080, 16'hff80, 16'h0040, 16'hffc0, 16'h0020, 16'hffe0}, 0);
    drain();
    // zero and full gain, raised floor, full period
    reg_write(RegLeg1Gain, 16'd0);
    reg_write(RegLeg2Gain, 16'hffff);
    reg_write(RegFloor, 16'd50);
    reg_write(RegPeriod, 16'hffff);
    send_errors({6{16'h8000}}, 0);
    send_errors({16'h0, 16'h1, 16'hffff, 16'h7fff, 16'h0, 16'h0}, 0);
    send_errors('0, 0);
    drain();
    // period zero: every pulse sits on the floor
    reg_write(RegPeriod, 16'd0);
    reg_write(RegFloor, 16'hffff);
    send_errors({6{16'h7fff}}, 0);
    send_errors({16'h1234, 16'h8000, 16'h0, 16'hffff, 16'h0001, 16'h4000}, 0);
    drain();
    reg_write(RegPeriod, 16'd1);
    reg_write(RegFloor, 16'd0);
    send_errors({6{16'h8000}}, 0);
    send_errors({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100}, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 6; i++) reg_write(i[RegIdxW-1:0], rand_gain());
      case (ph % 4)
        0: v = 16'hffff;
        1: v = 16'd1;
        2: v = 16'd1000;
        default: v = 16'($urandom_range(1, 65535));
      endcase
      reg_write(RegPeriod, v);
      reg_write(RegFloor, ph % 3 == 0 ? 16'd0 : 16'($urandom_range(0, 2 * v)));
      if (ph == 2) rx_hold = 1;
      for (int n = 0; n < 190; n++) begin
        for (int i = 0; i < 6; i++) d[16*i +: 16] = rand_err();
        send_errors(d, ph == 2 || (n % 40) < 10);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
